[src/min_hop_tree_parent_and_forward_queue_unit_defines.svh]
// ----------------------------------------------------------------------------
// min-hop tree node assertion macros
// shared property shapes for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MIN_HOP_TREE_PARENT_AND_FORWARD_QUEUE_UNIT_DEFINES_SVH
`define MIN_HOP_TREE_PARENT_AND_FORWARD_QUEUE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mht_pkg.sv]
// ----------------------------------------------------------------------------
// min-hop tree node package
// request codes, result codes, register indexes and shared types
// ----------------------------------------------------------------------------
`default_nettype none

package mht_pkg;

    // event kinds carried in the input tuser
    typedef enum logic [2:0] {
        REQ_BEACON    = 3'd0,
        REQ_DATA      = 3'd1,
        REQ_ORIGINATE = 3'd2,
        REQ_TRANSMIT  = 3'd3,
        REQ_HEARTBEAT = 3'd4,
        REQ_TICK      = 3'd5
    } t_req;

    // result codes carried in the output tuser
    typedef enum logic [3:0] {
        ST_IGNORED     = 4'd0,
        ST_PARENT_UPD  = 4'd1,
        ST_QUEUED      = 4'd2,
        ST_DROPPED     = 4'd3,
        ST_DELIVERED   = 4'd4,
        ST_SENT        = 4'd5,
        ST_IDLE        = 4'd6,
        ST_BEACON      = 4'd7,
        ST_PARENT_LOST = 4'd8
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NODE_ID        = 2'd0,
        CFG_QUEUE_LIMIT    = 2'd1,
        CFG_PARENT_TIMEOUT = 2'd2
    } t_cfg_idx;

    // control sequencer states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_state;

    localparam int          QCNT_W            = 5;
    localparam logic [15:0] NODE_ID_RST       = 16'd0;
    localparam logic [4:0]  QUEUE_LIMIT_RST   = 5'd10;
    localparam logic [15:0] PARENT_TIMEOUT_RST = 16'd30;
    localparam logic [16:0] NO_PARENT         = 17'h1FFFF;
    localparam logic [15:0] AGE_MAX           = 16'hFFFF;

    // one queued packet
    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] orig;
    } t_pkt;

    // queue requests from the control path
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_q_req;

endpackage

`default_nettype wire

[src/mht_pkt_mem.sv]
// ----------------------------------------------------------------------------
// packet store
// single-port-write, registered-read memory holding queued packets
// ----------------------------------------------------------------------------
`default_nettype none

module mht_pkt_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[src/mht_queue.sv]
// ----------------------------------------------------------------------------
// forwarding queue
// head/tail pointers and occupancy around the packet store
// ----------------------------------------------------------------------------
`default_nettype none

module mht_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mht_pkg::t_q_req                i_req,
    input  wire mht_pkg::t_pkt                  i_push_pkt,
    output      mht_pkg::t_pkt                  o_head_pkt,
    output      logic [mht_pkg::QCNT_W-1:0]     o_occ
);
    import mht_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [QCNT_W-1:0] r_occ, n_occ;
    logic [$bits(t_pkt)-1:0] rd_data;

    // pointer and count update with wrap at the store depth
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (i_req.push) begin
            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
            n_occ  = r_occ + 1'b1;
        end
        if (i_req.pop) begin
            n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
            n_occ  = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    mht_pkt_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W ($bits(t_pkt))
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.push),
        .i_wr_addr (r_tail),
        .i_wr_data (i_push_pkt),
        .i_rd_en   (i_req.rd),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    assign o_head_pkt = t_pkt'(rd_data);
    assign o_occ      = r_occ;

endmodule

`default_nettype wire

[src/min_hop_tree_parent_and_forward_queue_unit.sv]
// A result is registered when its request executes, which stalls while an
// earlier result is unaccepted. Requests are taken only while idle; the
// packet store's registered read of the queue head comes first, then the
// update and result. A waiting result does not block the next acceptance.
// Reset: i_rst_n synchronous, active low; the packet store needs no clearing.
// ----------------------------------------------------------------------------
// min-hop collection tree node
// parent selection from beacons plus a forwarding queue toward the parent
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_hop_tree_parent_and_forward_queue_unit_defines.svh"

module min_hop_tree_parent_and_forward_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int INFINITE_HOPS = 255
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // request stream
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // [15:0] sender_id, [32:16] sender_parent, [40:33] sender_hops,
    // [72:41] src_addr, [104:73] hdr_addr, [120:105] pkt_originator,
    // [152:121] pkt_seq, [159:153] zero
    input  wire logic [159:0] s_tdata,
    // [2:0] req_type
    input  wire logic [2:0]   s_tuser,
    // result stream
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // [15:0] out_originator, [47:16] out_seq, [79:48] out_dest_addr,
    // [96:80] parent_id, [104:97] hop_count, [109:105] queue_count,
    // [141:110] count_originated, [173:142] count_sent,
    // [205:174] count_delivered, [237:206] count_dropped, [239:238] zero
    output      logic [239:0] m_tdata,
    // [3:0] status
    output      logic [3:0]   m_tuser,
    // configuration writes
    input  wire logic         i_cfg_valid,
    output      logic         o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    import mht_pkg::*;

    localparam logic [7:0] INF_HOPS = 8'(INFINITE_HOPS);
    localparam int         LIM_CAP  = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
    localparam logic [QCNT_W-1:0] LIM_CAP_V = QCNT_W'(LIM_CAP);

    // configuration registers
    logic [15:0]       r_node_id;
    logic [4:0]        r_queue_limit;
    logic [15:0]       r_parent_timeout;

    // sequencer
    t_state r_state, n_state;
    logic   accept;
    logic   exec_fire;

    // captured request
    t_req          r_req;
    logic [152:0]  r_in;
    logic [15:0]   in_sid;
    logic [16:0]   in_spar;
    logic [7:0]    in_shops;
    logic [31:0]   in_saddr;
    logic [31:0]   in_haddr;
    logic [15:0]   in_porig;
    logic [31:0]   in_pseq;

    // routing state and counters
    logic [16:0] r_parent, n_parent;
    logic [7:0]  r_hops, n_hops;
    logic [31:0] r_paddr, n_paddr;
    logic [15:0] r_age, n_age;
    logic [31:0] r_next_seq, n_next_seq;
    logic [31:0] r_cnt_orig, n_cnt_orig;
    logic [31:0] r_cnt_sent, n_cnt_sent;
    logic [31:0] r_cnt_deliv, n_cnt_deliv;
    logic [31:0] r_cnt_drop, n_cnt_drop;

    // queue interface
    t_q_req            q_req;
    t_pkt              q_push_pkt;
    t_pkt              q_head_pkt;
    logic [QCNT_W-1:0] q_occ;
    logic [QCNT_W-1:0] eff_limit;
    logic              q_full;
    logic [QCNT_W-1:0] occ_after;

    // result being formed
    t_status     res_status;
    logic [15:0] res_orig;
    logic [31:0] res_seq;
    logic [31:0] res_dest;

    // output register
    logic        r_m_valid;
    t_status     r_m_status;
    logic [15:0] r_m_orig;
    logic [31:0] r_m_seq;
    logic [31:0] r_m_dest;
    logic [16:0] r_m_parent;
    logic [7:0]  r_m_hops;
    logic [QCNT_W-1:0] r_m_occ;
    logic [31:0] r_m_cnt_orig;
    logic [31:0] r_m_cnt_sent;
    logic [31:0] r_m_cnt_deliv;
    logic [31:0] r_m_cnt_drop;

    // beacon decode
    logic [31:0] bcn_addr;
    logic [7:0]  bcn_cand;
    logic        bcn_valid;
    logic        bcn_from_parent;
    logic        has_parent;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id        <= NODE_ID_RST;
            r_queue_limit    <= QUEUE_LIMIT_RST;
            r_parent_timeout <= PARENT_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_ID:        r_node_id        <= i_cfg_data;
                CFG_QUEUE_LIMIT:    r_queue_limit    <= i_cfg_data[4:0];
                CFG_PARENT_TIMEOUT: r_parent_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FSM_IDLE: if (s_tvalid) n_state = FSM_EXEC;
            FSM_EXEC: if (exec_fire) n_state = FSM_IDLE;
            default:  n_state = FSM_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        unique case (r_state)
            FSM_IDLE: s_tready  = 1'b1;
            FSM_EXEC: exec_fire = !r_m_valid || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(s_tuser);
            r_in  <= s_tdata[152:0];
        end
    end

    assign in_sid   = r_in[15:0];
    assign in_spar  = r_in[32:16];
    assign in_shops = r_in[40:33];
    assign in_saddr = r_in[72:41];
    assign in_haddr = r_in[104:73];
    assign in_porig = r_in[120:105];
    assign in_pseq  = r_in[152:121];

    // queue limit clipped to the store depth, at most 31
    assign eff_limit = (r_queue_limit > LIM_CAP_V) ? LIM_CAP_V : r_queue_limit;
    assign q_full    = (q_occ >= eff_limit);

    // beacon qualification
    assign has_parent      = !r_parent[16];
    assign bcn_addr        = (in_haddr != 32'd0) ? in_haddr : in_saddr;
    assign bcn_cand        = in_shops + 8'd1;
    assign bcn_valid       = (in_sid != r_node_id) && (r_node_id != 16'd0) &&
                             (in_shops < INF_HOPS) && (in_spar != {1'b0, r_node_id});
    assign bcn_from_parent = has_parent && (r_parent[15:0] == in_sid);

    // event execution
    always_comb begin
        n_parent    = r_parent;
        n_hops      = r_hops;
        n_paddr     = r_paddr;
        n_age       = r_age;
        n_next_seq  = r_next_seq;
        n_cnt_orig  = r_cnt_orig;
        n_cnt_sent  = r_cnt_sent;
        n_cnt_deliv = r_cnt_deliv;
        n_cnt_drop  = r_cnt_drop;
        q_req       = '0;
        q_push_pkt  = '0;
        res_status  = ST_IGNORED;
        res_orig    = '0;
        res_seq     = '0;
        res_dest    = '0;
        q_req.rd    = accept;
        unique case (r_req)
            REQ_BEACON: begin
                if (bcn_valid) begin
                    if (bcn_from_parent) begin
                        n_age      = '0;
                        n_hops     = bcn_cand;
                        n_paddr    = bcn_addr;
                        res_status = ST_PARENT_UPD;
                    end else if (bcn_cand < r_hops) begin
                        n_parent   = {1'b0, in_sid};
                        n_hops     = bcn_cand;
                        n_paddr    = bcn_addr;
                        n_age      = '0;
                        res_status = ST_PARENT_UPD;
                    end
                end
            end
            REQ_DATA: begin
                if (r_node_id == 16'd0) begin
                    n_cnt_deliv = r_cnt_deliv + 32'd1;
                    res_status  = ST_DELIVERED;
                end else if (q_full) begin
                    n_cnt_drop = r_cnt_drop + 32'd1;
                    res_status = ST_DROPPED;
                end else begin
                    q_req.push      = exec_fire;
                    q_push_pkt.orig = in_porig;
                    q_push_pkt.seq  = in_pseq;
                    res_status      = ST_QUEUED;
                end
            end
            REQ_ORIGINATE: begin
                if (q_full) begin
                    n_cnt_drop = r_cnt_drop + 32'd1;
                    res_status = ST_DROPPED;
                end else begin
                    q_req.push      = exec_fire;
                    q_push_pkt.orig = r_node_id;
                    q_push_pkt.seq  = r_next_seq;
                    n_next_seq      = r_next_seq + 32'd1;
                    n_cnt_orig      = r_cnt_orig + 32'd1;
                    res_status      = ST_QUEUED;
                end
            end
            REQ_TRANSMIT: begin
                if ((q_occ != '0) && has_parent && (r_paddr != 32'd0) &&
                    (r_node_id != 16'd0)) begin
                    q_req.pop  = exec_fire;
                    res_orig   = q_head_pkt.orig;
                    res_seq    = q_head_pkt.seq;
                    res_dest   = r_paddr;
                    n_cnt_sent = r_cnt_sent + 32'd1;
                    res_status = ST_SENT;
                end else begin
                    res_status = ST_IDLE;
                end
            end
            REQ_HEARTBEAT: begin
                res_status = ST_BEACON;
                if (r_node_id == 16'd0) begin
                    n_parent = NO_PARENT;
                    n_hops   = 8'd0;
                end else if (has_parent && (r_age > r_parent_timeout)) begin
                    n_parent   = NO_PARENT;
                    n_hops     = INF_HOPS;
                    n_paddr    = '0;
                    res_status = ST_PARENT_LOST;
                end
            end
            REQ_TICK: begin
                if (r_age != AGE_MAX) begin
                    n_age = r_age + 16'd1;
                end
            end
            default: ;
        endcase
    end

    // reported queue count after this event
    assign occ_after = q_occ + QCNT_W'(q_req.push) - QCNT_W'(q_req.pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent    <= NO_PARENT;
            r_hops      <= INF_HOPS;
            r_paddr     <= '0;
            r_age       <= '0;
            r_next_seq  <= '0;
            r_cnt_orig  <= '0;
            r_cnt_sent  <= '0;
            r_cnt_deliv <= '0;
            r_cnt_drop  <= '0;
        end else if (exec_fire) begin
            r_parent    <= n_parent;
            r_hops      <= n_hops;
            r_paddr     <= n_paddr;
            r_age       <= n_age;
            r_next_seq  <= n_next_seq;
            r_cnt_orig  <= n_cnt_orig;
            r_cnt_sent  <= n_cnt_sent;
            r_cnt_deliv <= n_cnt_deliv;
            r_cnt_drop  <= n_cnt_drop;
        end
    end

    mht_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (q_req),
        .i_push_pkt (q_push_pkt),
        .o_head_pkt (q_head_pkt),
        .o_occ      (q_occ)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (exec_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_m_status    <= res_status;
            r_m_orig      <= res_orig;
            r_m_seq       <= res_seq;
            r_m_dest      <= res_dest;
            r_m_parent    <= n_parent;
            r_m_hops      <= n_hops;
            r_m_occ       <= occ_after;
            r_m_cnt_orig  <= n_cnt_orig;
            r_m_cnt_sent  <= n_cnt_sent;
            r_m_cnt_deliv <= n_cnt_deliv;
            r_m_cnt_drop  <= n_cnt_drop;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_status;
    assign m_tdata  = {2'b00, r_m_cnt_drop, r_m_cnt_deliv, r_m_cnt_sent, r_m_cnt_orig,
                       r_m_occ, r_m_hops, r_m_parent, r_m_dest, r_m_seq, r_m_orig};

    // checks
    `MHT_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, accept,
        r_state == FSM_EXEC, "accepted request did not enter execution")
    `MHT_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, exec_fire,
        m_tvalid, "executed request produced no result")
    `MHT_ASSERT_NEXT(a_sent_pops_queue, i_clk, i_rst_n,
        exec_fire && (res_status == ST_SENT),
        q_occ == $past(q_occ) - 1'b1, "sent packet did not leave the queue")
    `MHT_ASSERT_NOW(a_sent_needs_packet, i_clk, i_rst_n,
        exec_fire && (res_status == ST_SENT), q_occ != '0,
        "packet sent from an empty queue")

endmodule

`default_nettype wire
